FILE: hw/rtl/gsa_pkg.sv
// Shared types and codes for the generational slot allocator.
package gsa_pkg;

    // Request codes
    localparam logic [2:0] REQ_ALLOC = 3'd0;
    localparam logic [2:0] REQ_FREE  = 3'd1;
    localparam logic [2:0] REQ_CHECK = 3'd2;
    localparam logic [2:0] REQ_FIND  = 3'd3;
    localparam logic [2:0] REQ_CLEAR = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOT_LIVE = 2'd2;

    // Widest slot address (up to 256 slots) and widest generation
    localparam int SLOT_ADDR_W = 8;
    localparam int GEN_MAX_W   = 32;
    localparam int ALU_W       = 32;

    typedef struct packed {
        logic [2:0]        req_type;
        logic [4:0]        slot_index;
        logic              handle_defined;
        logic [7:0]        generation;
        logic signed [7:0] level_tag;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic       found;
        logic [4:0] slot_out;
        logic [7:0] generation_out;
    } t_rsp;

    typedef enum logic [1:0] {
        ALU_LT  = 2'd0,
        ALU_EQ  = 2'd1,
        ALU_INC = 2'd2
    } t_alu_op;

    // Commands from the sequencer to the slot store
    typedef struct packed {
        logic                   clear_all;
        logic                   live_set;
        logic                   live_clr;
        logic                   gen_rd;
        logic                   gen_wr;
        logic                   tag_rd;
        logic                   tag_wr;
        logic [SLOT_ADDR_W-1:0] addr;
        logic [GEN_MAX_W-1:0]   gen_wdata;
        logic [7:0]             tag_wdata;
    } t_store_cmd;

endpackage

FILE: hw/rtl/generational_slot_allocator.sv
// Top level of the generational slot allocator: request sequencer and result register.
//
// Usage
//   Request channel: drive i_req and raise i_start; the item is taken at the rising
//   edge where i_start is high and o_busy is low. o_busy stays high while a request
//   is being worked on.
//   Result channel: every request yields exactly one result, shown on o_rsp for one
//   cycle with o_valid high. The receiver cannot stall; it must take the result then.
//   The sequencer walks one slot per cycle through the shared compare unit and the
//   single-port slot memories when it allocates or finds. Free and check of a live
//   slot read the generation before answering. Clear all, unknown codes, an
//   out-of-range base, free of a dead slot and check of a dead or undefined handle
//   are answered straight from the idle state.
//   A new request may be taken in the same cycle that the previous result is shown.
//   Reset clears every live bit and every generation at once through per-slot valid
//   bits, so there is no clearing pass; the block is ready the cycle after reset.
module generational_slot_allocator #(
    parameter int SLOTS    = 32,
    parameter int GEN_BITS = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  gsa_pkg::t_req i_req,
    output logic          o_busy,
    output logic          o_valid,
    output gsa_pkg::t_rsp o_rsp
);
    import gsa_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(SLOTS - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_GEN  = 4'b0100,
        S_FIND = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    t_req              r_req, n_req;
    t_rsp              r_rsp, n_rsp;
    logic              r_valid, n_valid;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_slot, n_slot;
    logic [CNT_W-1:0]  r_pidx, n_pidx;
    logic              r_pend, n_pend;
    logic              r_issued, n_issued;

    t_store_cmd          cmd;
    logic [SLOTS-1:0]    w_live;
    logic [GEN_BITS-1:0] w_gen_rd;
    logic [7:0]          w_tag_rd;

    t_alu_op             alu_op;
    logic [ALU_W-1:0]    alu_a, alu_b, alu_res;
    logic                alu_flag;

    gsa_store #(
        .SLOTS    (SLOTS),
        .GEN_BITS (GEN_BITS)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_live      (w_live),
        .o_gen_rdata (w_gen_rd),
        .o_tag_rdata (w_tag_rd)
    );

    gsa_alu u_alu (
        .i_op   (alu_op),
        .i_a    (alu_a),
        .i_b    (alu_b),
        .o_flag (alu_flag),
        .o_res  (alu_res)
    );

    // Route operands to the shared unit according to the current step
    always_comb begin
        alu_op = ALU_LT;
        alu_a  = ALU_W'(i_req.slot_index);
        alu_b  = ALU_W'(SLOTS);
        case (r_state)
            S_SCAN: begin
                alu_a = ALU_W'(r_cnt);
            end
            S_GEN: begin
                alu_a = ALU_W'(w_gen_rd);
                if (r_req.req_type == REQ_FREE) begin
                    alu_op = ALU_INC;
                end else begin
                    alu_op = ALU_EQ;
                    alu_b  = ALU_W'(r_req.generation);
                end
            end
            S_FIND: begin
                alu_op = ALU_EQ;
                alu_a  = ALU_W'(w_tag_rd);
                alu_b  = {24'd0, r_req.level_tag};
            end
            default: begin
                alu_op = ALU_LT;
            end
        endcase
    end

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_req    = r_req;
        n_cnt    = r_cnt;
        n_slot   = r_slot;
        n_pidx   = r_pidx;
        n_pend   = 1'b0;
        n_issued = r_issued;
        n_valid  = 1'b0;
        n_rsp    = '0;
        cmd      = '0;
        cmd.tag_wdata = r_req.level_tag;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_req  = i_req;
                    n_cnt  = CNT_W'(i_req.slot_index);
                    n_slot = CNT_W'(i_req.slot_index);
                    cmd.addr = SLOT_ADDR_W'(i_req.slot_index);
                    case (i_req.req_type)
                        REQ_ALLOC: begin
                            if (alu_flag) begin
                                n_state = S_SCAN;
                            end else begin
                                n_valid      = 1'b1;
                                n_rsp.status = ST_FULL;
                            end
                        end
                        REQ_FREE: begin
                            if (alu_flag && w_live[IDX_W'(i_req.slot_index)]) begin
                                cmd.gen_rd = 1'b1;
                                n_state    = S_GEN;
                            end else begin
                                n_valid      = 1'b1;
                                n_rsp.status = ST_NOT_LIVE;
                            end
                        end
                        REQ_CHECK: begin
                            if (i_req.handle_defined && alu_flag &&
                                w_live[IDX_W'(i_req.slot_index)]) begin
                                cmd.gen_rd = 1'b1;
                                n_state    = S_GEN;
                            end else begin
                                n_valid = 1'b1;
                            end
                        end
                        REQ_FIND: begin
                            n_cnt    = '0;
                            n_issued = 1'b0;
                            n_state  = S_FIND;
                        end
                        REQ_CLEAR: begin
                            cmd.clear_all = 1'b1;
                            n_valid       = 1'b1;
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end

            // Walk upward from the base until a free slot turns up or the pool ends
            S_SCAN: begin
                cmd.addr = SLOT_ADDR_W'(r_cnt);
                if (!alu_flag) begin
                    n_valid      = 1'b1;
                    n_rsp.status = ST_FULL;
                    n_state      = S_IDLE;
                end else if (!w_live[r_cnt[IDX_W-1:0]]) begin
                    cmd.live_set = 1'b1;
                    cmd.tag_wr   = 1'b1;
                    cmd.gen_rd   = 1'b1;
                    n_slot       = r_cnt;
                    n_state      = S_GEN;
                end else begin
                    n_cnt = CNT_W'(r_cnt + 1'b1);
                end
            end

            // Generation read has landed: finish allocate, free or check
            S_GEN: begin
                cmd.addr = SLOT_ADDR_W'(r_slot);
                n_valid  = 1'b1;
                n_state  = S_IDLE;
                case (r_req.req_type)
                    REQ_ALLOC: begin
                        n_rsp.slot_out       = 5'(r_slot);
                        n_rsp.generation_out = 8'(w_gen_rd);
                    end
                    REQ_FREE: begin
                        cmd.gen_wr    = 1'b1;
                        cmd.gen_wdata = GEN_MAX_W'(alu_res[GEN_BITS-1:0]);
                        cmd.live_clr  = 1'b1;
                    end
                    REQ_CHECK: begin
                        n_rsp.found = alu_flag;
                    end
                    default: begin
                        n_rsp = '0;
                    end
                endcase
            end

            // Issue one tag read a cycle; compare the previous one as it lands
            S_FIND: begin
                cmd.addr = SLOT_ADDR_W'(r_cnt);
                if (r_pend && w_live[r_pidx[IDX_W-1:0]] && alu_flag) begin
                    n_valid     = 1'b1;
                    n_rsp.found = 1'b1;
                    n_state     = S_IDLE;
                end else if (r_pend && (r_pidx == LAST)) begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else if (!r_issued) begin
                    cmd.tag_rd = 1'b1;
                    n_pend     = 1'b1;
                    n_pidx     = r_cnt;
                    if (r_cnt == LAST) begin
                        n_issued = 1'b1;
                    end else begin
                        n_cnt = CNT_W'(r_cnt + 1'b1);
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= 1'b0;
            r_pend   <= 1'b0;
            r_issued <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_pend   <= n_pend;
            r_issued <= n_issued;
        end
    end

    // Hold payload without reset
    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_rsp  <= n_rsp;
        r_cnt  <= n_cnt;
        r_slot <= n_slot;
        r_pidx <= n_pidx;
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    // An accepted item either starts work or answers at once
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy || o_valid))
        else $error("accepted item neither started nor answered");

    // A result is only shown once the sequencer is back at rest
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy)
        else $error("result shown while still busy");

    // The slot being finished is always live while its generation is used
    a_gen_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GEN) |-> w_live[r_slot[IDX_W-1:0]])
        else $error("generation step on a dead slot");

    // A pending tag compare never points past the pool
    a_pend_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_pidx <= LAST))
        else $error("tag compare index out of range");

endmodule

FILE: hw/rtl/gsa_alu.sv
// Shared compare and increment unit used by every step of the sequencer.
module gsa_alu (
    input  gsa_pkg::t_alu_op          i_op,
    input  logic [gsa_pkg::ALU_W-1:0] i_a,
    input  logic [gsa_pkg::ALU_W-1:0] i_b,
    output logic                      o_flag,
    output logic [gsa_pkg::ALU_W-1:0] o_res
);
    import gsa_pkg::*;

    always_comb begin
        o_flag = 1'b0;
        o_res  = i_a;
        case (i_op)
            ALU_LT:  o_flag = (i_a < i_b);
            ALU_EQ:  o_flag = (i_a == i_b);
            ALU_INC: o_res  = i_a + 1'b1;
            default: o_flag = 1'b0;
        endcase
    end

endmodule

FILE: hw/rtl/gsa_store.sv
// Slot store: live bits, generation memory with reset-valid bits, tag memory.
module gsa_store #(
    parameter int SLOTS    = 32,
    parameter int GEN_BITS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gsa_pkg::t_store_cmd i_cmd,
    output logic [SLOTS-1:0]    o_live,
    output logic [GEN_BITS-1:0] o_gen_rdata,
    output logic [7:0]          o_tag_rdata
);
    import gsa_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [SLOTS-1:0]    r_live;
    logic [SLOTS-1:0]    r_gen_vld;
    logic [GEN_BITS-1:0] r_gen_mem [SLOTS];
    logic [7:0]          r_tag_mem [SLOTS];
    logic [GEN_BITS-1:0] r_gen_q;
    logic                r_gen_q_vld;
    logic [7:0]          r_tag_q;
    logic [IDX_W-1:0]    addr;

    assign addr = i_cmd.addr[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live    <= '0;
            r_gen_vld <= '0;
        end else begin
            if (i_cmd.clear_all) begin
                r_live <= '0;
            end else if (i_cmd.live_set) begin
                r_live[addr] <= 1'b1;
            end else if (i_cmd.live_clr) begin
                r_live[addr] <= 1'b0;
            end
            if (i_cmd.gen_wr) begin
                r_gen_vld[addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.gen_wr) begin
            r_gen_mem[addr] <= i_cmd.gen_wdata[GEN_BITS-1:0];
        end
        if (i_cmd.gen_rd) begin
            r_gen_q     <= r_gen_mem[addr];
            r_gen_q_vld <= r_gen_vld[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tag_wr) begin
            r_tag_mem[addr] <= i_cmd.tag_wdata;
        end
        if (i_cmd.tag_rd) begin
            r_tag_q <= r_tag_mem[addr];
        end
    end

    // A generation never written reads as its reset value of zero
    assign o_gen_rdata = r_gen_q_vld ? r_gen_q : '0;
    assign o_tag_rdata = r_tag_q;
    assign o_live      = r_live;

endmodule

FILE: tb/sv/generational_slot_allocator_tb.sv
// Self-checking testbench for the generational slot allocator: directed and random request items.
`timescale 1ns / 100ps

module generational_slot_allocator_tb;

    import gsa_pkg::*;

    localparam int SLOT_COUNT = 32;
    localparam int GEN_W      = 8;
    localparam int REQ_W      = $bits(t_req);

    // Watchdog: cycles in a row in which neither an item nor a result is taken
    localparam int unsigned WATCHDOG_LIMIT = 4000;

    // Request codes the block must ignore
    localparam logic [2:0] REQ_RSVD_5 = 3'd5;
    localparam logic [2:0] REQ_RSVD_6 = 3'd6;
    localparam logic [2:0] REQ_RSVD_7 = 3'd7;

    // Predicts the slot map and queues the result each accepted item must give
    class slot_map_scoreboard;
        bit             live[SLOT_COUNT];
        bit [GEN_W-1:0] gen[SLOT_COUNT];
        bit [7:0]       tag[SLOT_COUNT];
        t_rsp           expected_q[$];
        int unsigned    mismatches;

        function new();
            int i;
            for (i = 0; i < SLOT_COUNT; i++) begin
                live[i] = 1'b0;
                gen[i]  = '0;
                tag[i]  = '0;
            end
            mismatches = 0;
        endfunction

        function void note_request(t_req r);
            t_rsp e;
            int   i;
            bit   granted;
            e       = '0;
            granted = 1'b0;
            case (r.req_type)
                REQ_ALLOC: begin
                    e.status = ST_FULL;
                    for (i = int'(r.slot_index); i < SLOT_COUNT; i++) begin
                        if (!granted && !live[i]) begin
                            live[i]          = 1'b1;
                            tag[i]           = r.level_tag;
                            e.slot_out       = 5'(i);
                            e.generation_out = gen[i];
                            e.status         = ST_OK;
                            granted          = 1'b1;
                        end
                    end
                end
                REQ_FREE: begin
                    if (live[r.slot_index]) begin
                        live[r.slot_index] = 1'b0;
                        gen[r.slot_index]  = gen[r.slot_index] + 1'b1;
                    end else begin
                        e.status = ST_NOT_LIVE;
                    end
                end
                REQ_CHECK: begin
                    e.found = r.handle_defined && live[r.slot_index] &&
                              (gen[r.slot_index] == r.generation);
                end
                REQ_FIND: begin
                    for (i = 0; i < SLOT_COUNT; i++) begin
                        if (live[i] && tag[i] == r.level_tag) begin
                            e.found = 1'b1;
                        end
                    end
                end
                REQ_CLEAR: begin
                    for (i = 0; i < SLOT_COUNT; i++) begin
                        live[i] = 1'b0;
                    end
                end
                default: begin
                end
            endcase
            expected_q.push_back(e);
        endfunction

        function void check_result(t_rsp got);
            t_rsp want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $write("%0t: result with nothing pending: ", $realtime);
                    $display("status=%0d found=%0d slot=%0d gen=%0d",
                             got.status, got.found, got.slot_out, got.generation_out);
                end
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status || got.found !== want.found ||
                got.slot_out !== want.slot_out || got.generation_out !== want.generation_out) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $write("%0t: mismatch: expected status=%0d found=%0d slot=%0d gen=%0d, ",
                           $realtime, want.status, want.found, want.slot_out,
                           want.generation_out);
                    $display("got status=%0d found=%0d slot=%0d gen=%0d",
                             got.status, got.found, got.slot_out, got.generation_out);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Pick one live slot at random; return 0 when the pool is empty
        function bit pick_live(output logic [4:0] idx);
            int live_idx[$];
            int i;
            for (i = 0; i < SLOT_COUNT; i++) begin
                if (live[i]) begin
                    live_idx.push_back(i);
                end
            end
            idx = '0;
            if (live_idx.size() == 0) begin
                return 1'b0;
            end
            idx = 5'(live_idx[$urandom_range(live_idx.size() - 1)]);
            return 1'b1;
        endfunction

        function bit [GEN_W-1:0] generation_of(logic [4:0] idx);
            return gen[idx];
        endfunction

        function bit [7:0] tag_of(logic [4:0] idx);
            return tag[idx];
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_start;
    t_req i_req;
    logic o_busy;
    logic o_valid;
    t_rsp o_rsp;

    slot_map_scoreboard sb;
    int unsigned        idle_pct;
    int unsigned        quiet_cycles = 0;

    // Sender idle share per phase; the third entry stands for the receiver-stall
    // phase, which cannot apply since results cannot be held off
    int unsigned idle_plan[4] = '{0, 74, 0, 14};

    generational_slot_allocator #(
        .SLOTS    (SLOT_COUNT),
        .GEN_BITS (GEN_W)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_req   (i_req),
        .o_busy  (o_busy),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Sample both channels at the rising edge. Check the result before noting
    // a new item: a result shown in the cycle an item is taken belongs to an
    // older item. Count quiet cycles for the watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) begin
                sb.check_result(o_rsp);
            end
            if (i_start && !o_busy) begin
                sb.note_request(i_req);
            end
            if (o_valid || (i_start && !o_busy)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles = quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: nothing taken for %0d cycles", quiet_cycles);
                $display("generational_slot_allocator_tb: done, errors");
                $finish;
            end
        end
    end

    function automatic t_req req_of(logic [2:0] kind, logic [4:0] idx, logic def,
                                    logic [7:0] gen, logic [7:0] tag);
        t_req r;
        r.req_type       = kind;
        r.slot_index     = idx;
        r.handle_defined = def;
        r.generation     = gen;
        r.level_tag      = tag;
        return r;
    endfunction

    // Drive one item. Enter and leave at a falling edge, so the scoreboard has
    // already seen the previous item when the next one is built. Idle the
    // request line at random beforehand, with noise on the payload.
    task automatic issue_request(input t_req r);
        while ($urandom_range(99) < idle_pct) begin
            i_start = 1'b0;
            i_req   = REQ_W'($urandom());
            @(negedge i_clk);
        end
        i_start = 1'b1;
        i_req   = r;
        do @(posedge i_clk); while (o_busy);
        @(negedge i_clk);
    endtask

    // Build a random item: mostly well-formed handles taken from the predicted
    // map, some noise with every field random (reserved codes included)
    function automatic t_req random_request(input int unsigned alloc_w,
                                            input int unsigned free_w);
        t_req        r;
        logic [4:0]  s;
        int unsigned roll;
        r = REQ_W'($urandom());
        if ($urandom_range(99) < 10) begin
            return r;
        end
        roll = $urandom_range(99);
        if (roll < alloc_w) begin
            r.req_type   = REQ_ALLOC;
            // favour low bases so the pool fills up from the bottom
            r.slot_index = ($urandom_range(3) == 0) ? 5'($urandom_range(31))
                                                    : 5'($urandom_range(3));
        end else if (roll < alloc_w + free_w) begin
            r.req_type = REQ_FREE;
            if ($urandom_range(4) != 0 && sb.pick_live(s)) begin
                r.slot_index = s;
            end
        end else if (roll < alloc_w + free_w + 25) begin
            r.req_type       = REQ_CHECK;
            r.handle_defined = ($urandom_range(9) != 0);
            if ($urandom_range(3) != 0 && sb.pick_live(s)) begin
                r.slot_index = s;
                r.generation = sb.generation_of(s);
                // now and then hold a stale handle
                if ($urandom_range(3) == 0) begin
                    r.generation = sb.generation_of(s) - 8'd1;
                end
            end
        end else if (roll < alloc_w + free_w + 37) begin
            r.req_type = REQ_FIND;
            if ($urandom_range(1) != 0 && sb.pick_live(s)) begin
                r.level_tag = sb.tag_of(s);
            end
        end else begin
            r.req_type = REQ_CLEAR;
        end
        return r;
    endfunction

    task automatic run_random_phase(input int unsigned items, input int unsigned alloc_w,
                                    input int unsigned free_w);
        repeat (items) begin
            issue_request(random_request(alloc_w, free_w));
        end
    endtask

    // Allocate and free one slot over and over so that its generation wraps;
    // check the live handle now and then
    task automatic run_generation_churn(input logic [4:0] s, input int unsigned pairs);
        int unsigned n;
        issue_request(req_of(REQ_CLEAR, '0, 1'b0, '0, '0));
        for (n = 0; n < pairs; n++) begin
            issue_request(req_of(REQ_ALLOC, s, 1'b0, '0, 8'($urandom())));
            if (n % 8 == 0) begin
                issue_request(req_of(REQ_CHECK, s, 1'b1, sb.generation_of(s), '0));
            end
            issue_request(req_of(REQ_FREE, s, 1'b0, '0, '0));
        end
    endtask

    initial begin
        int phase;
        sb       = new();
        i_rst_n  = 1'b0;
        i_start  = 1'b0;
        i_req    = '0;
        idle_pct = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed items on an empty pool: dead handles, empty find, dead free
        issue_request(req_of(REQ_CHECK, 5'd0,  1'b1, 8'h00, 8'h00));
        issue_request(req_of(REQ_FIND,  5'd0,  1'b0, 8'h00, 8'h80));
        issue_request(req_of(REQ_FREE,  5'd0,  1'b0, 8'h00, 8'h00));
        // Extreme tags and bases; the top slot then blocks its own base
        issue_request(req_of(REQ_ALLOC, 5'd0,  1'b0, 8'h00, 8'h80));
        issue_request(req_of(REQ_ALLOC, 5'd31, 1'b0, 8'h00, 8'h7F));
        issue_request(req_of(REQ_ALLOC, 5'd31, 1'b1, 8'hFF, 8'h00));
        // Live, undefined and wrong-generation handles
        issue_request(req_of(REQ_CHECK, 5'd0,  1'b1, 8'h00, 8'h00));
        issue_request(req_of(REQ_CHECK, 5'd0,  1'b0, 8'h00, 8'h00));
        issue_request(req_of(REQ_CHECK, 5'd0,  1'b1, 8'hFF, 8'h00));
        issue_request(req_of(REQ_FIND,  5'd0,  1'b0, 8'h00, 8'h80));
        issue_request(req_of(REQ_FIND,  5'd31, 1'b1, 8'hFF, 8'h7F));
        issue_request(req_of(REQ_FIND,  5'd0,  1'b0, 8'h00, 8'h00));
        // Free twice; the old handle must go stale and the slot comes back one generation on
        issue_request(req_of(REQ_FREE,  5'd0,  1'b0, 8'h00, 8'h00));
        issue_request(req_of(REQ_FREE,  5'd0,  1'b0, 8'h00, 8'h00));
        issue_request(req_of(REQ_CHECK, 5'd0,  1'b1, 8'h00, 8'h00));
        issue_request(req_of(REQ_ALLOC, 5'd0,  1'b0, 8'h00, 8'h55));
        issue_request(req_of(REQ_CHECK, 5'd0,  1'b1, 8'h01, 8'h00));
        // Reserved codes with every field high
        issue_request(req_of(REQ_RSVD_5, 5'd31, 1'b1, 8'hFF, 8'hFF));
        issue_request(req_of(REQ_RSVD_6, 5'd31, 1'b1, 8'hFF, 8'hFF));
        issue_request(req_of(REQ_RSVD_7, 5'd31, 1'b1, 8'hFF, 8'hFF));
        // Clear all: nothing live afterwards, generations kept
        issue_request(req_of(REQ_CLEAR, 5'd0,  1'b0, 8'h00, 8'h00));
        issue_request(req_of(REQ_FIND,  5'd0,  1'b0, 8'h00, 8'h55));
        issue_request(req_of(REQ_CHECK, 5'd31, 1'b1, 8'h00, 8'h00));
        issue_request(req_of(REQ_ALLOC, 5'd1,  1'b0, 8'h00, 8'hAA));
        issue_request(req_of(REQ_FREE,  5'd31, 1'b0, 8'h00, 8'h00));

        // Fill the whole pool from base 0 and run into the full case
        idle_pct = 14;
        issue_request(req_of(REQ_CLEAR, 5'd0, 1'b0, 8'h00, 8'h00));
        repeat (SLOT_COUNT + 2) begin
            issue_request(req_of(REQ_ALLOC, 5'd0, 1'b0, 8'h00, 8'($urandom())));
        end

        // Alternate fill-heavy and drain-heavy phases across the idling plan
        for (phase = 0; phase < 8; phase++) begin
            idle_pct = idle_plan[phase % 4];
            if (phase % 2 == 0) begin
                run_random_phase(45, 45, 15);
            end else begin
                run_random_phase(45, 20, 40);
            end
        end

        idle_pct = 74;
        run_generation_churn(5'($urandom_range(31)), 130);
        idle_pct = 0;
        run_generation_churn(5'($urandom_range(31)), 260);
        i_start = 1'b0;

        // Drain, then give a stray result time to show up
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (SLOT_COUNT + 8) @(posedge i_clk);

        if (sb.mismatches == 0) begin
            $display("generational_slot_allocator_tb: done, clean");
        end else begin
            $display("generational_slot_allocator_tb: done, errors");
        end
        $finish;
    end

endmodule
